FILE: design/short_window_lz_decoder_defines.svh
`ifndef SHORT_WINDOW_LZ_DECODER_DEFINES_SVH
`define SHORT_WINDOW_LZ_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SWLZ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("short_window_lz_decoder: check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SWLZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("short_window_lz_decoder: check failed");

`endif

FILE: design/swlz_pkg.sv
`timescale 1ns / 1ps

package swlz_pkg;

    localparam int unsigned WINDOW  = 32;
    localparam int unsigned HIST_AW = $clog2(WINDOW);
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 3;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_EMIT
    } swlz_state_t;

endpackage

FILE: design/short_window_lz_decoder.sv
`timescale 1ns / 1ps
// Literal: the input beat is accepted, then the result beat is presented.
// Copy code of n bytes: each output byte takes a history read, a write back
// and a present step, in that order.
// Marker with more to follow: no result. One item in flight.
// Reset (aresetn low, synchronous) clears state, write pointer, marker flag
// and the 32 history valid bits; the history itself needs no clearing pass.
module short_window_lz_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // chunk_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] chunk_done, [1] truncated
);
    import swlz_pkg::*;

    swlz_state_t state_reg, state_next;

    logic [HIST_AW-1:0] wpos_reg, wpos_next;
    logic [HIST_AW-1:0] src_reg,  src_next;
    logic [LEN_W-1:0]   cnt_reg,  cnt_next;
    logic               pend_reg, pend_next;
    logic               last_reg, last_next;
    logic [BYTE_W-1:0]  obyte_reg, obyte_next;
    logic               run_last_reg, run_last_next;
    logic               done_reg, done_next;
    logic               trunc_reg, trunc_next;

    logic [WINDOW-1:0]  valid_reg;
    logic [BYTE_W-1:0]  hist_mem [WINDOW];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;

    logic               mem_we;
    logic [BYTE_W-1:0]  mem_wdata;
    logic               hist_clr;
    logic [BYTE_W-1:0]  copy_byte;

    assign copy_byte = rd_valid_reg ? rd_data_reg : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = obyte_reg;
    assign m_tlast  = run_last_reg;
    assign m_tuser  = {trunc_reg, done_reg};

    always_comb begin
        state_next    = state_reg;
        wpos_next     = wpos_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        last_next     = last_reg;
        obyte_next    = obyte_reg;
        run_last_next = run_last_reg;
        done_next     = done_reg;
        trunc_next    = trunc_reg;
        mem_we        = 1'b0;
        mem_wdata     = s_tdata;
        hist_clr      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    if (pend_reg) begin
                        pend_next     = 1'b0;
                        mem_we        = 1'b1;
                        wpos_next     = wpos_reg + 1'b1;
                        obyte_next    = s_tdata;
                        run_last_next = 1'b1;
                        done_next     = s_tlast;
                        trunc_next    = 1'b0;
                        state_next    = ST_EMIT;
                    end else if (s_tdata == MARKER_BYTE) begin
                        if (s_tlast) begin
                            obyte_next    = '0;
                            run_last_next = 1'b1;
                            done_next     = 1'b1;
                            trunc_next    = 1'b1;
                            state_next    = ST_EMIT;
                        end else begin
                            pend_next = 1'b1;
                        end
                    end else begin
                        // distance 32 - f from wpos is wpos + f modulo the window
                        src_next   = wpos_reg + s_tdata[BYTE_W-1:LEN_W];
                        cnt_next   = s_tdata[LEN_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                mem_we        = 1'b1;
                mem_wdata     = copy_byte;
                wpos_next     = wpos_reg + 1'b1;
                src_next      = src_reg + 1'b1;
                obyte_next    = copy_byte;
                run_last_next = (cnt_reg == '0);
                done_next     = (cnt_reg == '0) && last_reg;
                trunc_next    = 1'b0;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (run_last_reg) begin
                        if (last_reg) begin
                            // chunk end: drop history, rewind pointer
                            hist_clr  = 1'b1;
                            wpos_next = '0;
                            pend_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wpos_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wpos_reg  <= wpos_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || hist_clr) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wpos_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        obyte_reg    <= obyte_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
        trunc_reg    <= trunc_next;
        rd_valid_reg <= valid_reg[src_reg];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wpos_reg] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[src_reg];
    end

endmodule

FILE: design/swlz_checker.sv
`timescale 1ns / 1ps
`include "short_window_lz_decoder_defines.svh"

module swlz_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // a stalled result beat holds
    `SWLZ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // a truncated beat is a zero byte that closes both run and chunk
    `SWLZ_ASSERT_SAME(a_trunc_form, m_tvalid && m_tuser[1], (m_tdata == 8'h00) && m_tlast && m_tuser[0])

    // chunk end only on the last beat of a run
    `SWLZ_ASSERT_SAME(a_done_last, m_tvalid && m_tuser[0], m_tlast)

    // no new input beat while a result is waiting
    `SWLZ_ASSERT_SAME(a_one_item, m_tvalid, !s_tready)

endmodule

bind short_window_lz_decoder swlz_checker u_swlz_checker (.*);

FILE: tb/short_window_lz_decoder_test.sv
`timescale 1ns / 1ps

module short_window_lz_decoder_test;
    import swlz_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int RX_HOLD = 150;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;  // wait for all decoded bytes before offering
    } comp_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_done;
        logic       truncated;
    } decoded_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    comp_item_t comp_q[$];
    decoded_t   decoded_q[$];

    logic [7:0] hist [WINDOW];
    logic [4:0] wpos;
    bit         lit_pending;

    bit  beat_taken = 1'b0;
    bit  steady = 1'b0;
    int  in_cnt = 0;
    int  err_cnt = 0;
    int  idle_cnt = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold_left = 0;
    bit  rx_hold_done [2] = '{1'b0, 1'b0};

    short_window_lz_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WINDOW; i++) begin
            hist[i] = 8'h00;
        end
        wpos = 5'd0;
        lit_pending = 1'b0;
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic last);
        decoded_t    d;
        int unsigned cnt;
        int unsigned back_dist;
        logic [4:0]  src;
        logic [7:0]  v;
        if (lit_pending) begin
            lit_pending = 1'b0;
            hist[wpos] = b;
            wpos = wpos + 5'd1;
            d = '{b, 1'b1, last, 1'b0};
            decoded_q.push_back(d);
        end else if (b == MARKER_BYTE) begin
            if (last) begin
                d = '{8'h00, 1'b1, 1'b1, 1'b1};
                decoded_q.push_back(d);
            end else begin
                lit_pending = 1'b1;
            end
        end else begin
            cnt = int'(b[2:0]) + 1;
            back_dist = WINDOW - int'(b[7:3]);
            for (int unsigned k = 0; k < cnt; k++) begin
                // distance 32 wraps onto the slot about to be overwritten
                src = wpos - 5'(back_dist);
                v = hist[src];
                hist[wpos] = v;
                wpos = wpos + 5'd1;
                d = '{v, k + 1 == cnt, (k + 1 == cnt) && last, 1'b0};
                decoded_q.push_back(d);
            end
        end
        if (last) begin
            clear_window();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input bit drain);
        comp_item_t it;
        it = '{b, last, drain};
        comp_q.push_back(it);
    endtask

    task automatic push_random_chunk(inout int n);
        int  ntok;
        int  r;
        bit  fin;
        ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 10);
        for (int i = 0; i < ntok; i++) begin
            fin = (i == ntok - 1);
            r = $urandom_range(0, 99);
            if (fin && $urandom_range(0, 9) == 0) begin
                // end the chunk on a bare marker
                push_byte(MARKER_BYTE, 1'b1, $urandom_range(0, 24) == 0);
                n += 1;
            end else if (r < 40) begin
                push_byte(MARKER_BYTE, 1'b0, $urandom_range(0, 24) == 0);
                push_byte(8'($urandom_range(0, 255)), fin, 1'b0);
                n += 2;
            end else if (r < 88) begin
                push_byte(8'($urandom_range(0, 254)), fin, $urandom_range(0, 24) == 0);
                n += 1;
            end else begin
                push_byte(8'($urandom_range(0, 255)), fin, 1'b0);
                n += 1;
            end
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !beat_taken)) begin
            if (beat_taken) begin
                tx_gap = pick_gap();
            end
            beat_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (comp_q.size() > 0 &&
                         !(comp_q[0].drain && decoded_q.size() != 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= comp_q[0].data;
                s_tlast  <= comp_q[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if ((!rx_hold_done[0] && in_cnt >= 40) ||
                     (!rx_hold_done[1] && in_cnt >= 160)) begin
            // long back-pressure so the input side fills up and stalls
            if (!rx_hold_done[0]) begin
                rx_hold_done[0] = 1'b1;
            end else begin
                rx_hold_done[1] = 1'b1;
            end
            rx_hold_left = RX_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        decoded_t d;
        comp_item_t it;
        if (aresetn) begin
            idle_cnt++;
            if (m_tvalid && m_tready) begin
                idle_cnt = 0;
                if (decoded_q.size() == 0) begin
                    $error("unexpected beat: out_byte %0h run_last %0b user %0b",
                           m_tdata, m_tlast, m_tuser);
                    err_cnt++;
                end else begin
                    d = decoded_q.pop_front();
                    if (m_tdata !== d.out_byte) begin
                        $error("out_byte expected %0h actual %0h", d.out_byte, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== d.run_last) begin
                        $error("run_last expected %0b actual %0b", d.run_last, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser[0] !== d.chunk_done) begin
                        $error("chunk_done expected %0b actual %0b", d.chunk_done, m_tuser[0]);
                        err_cnt++;
                    end
                    if (m_tuser[1] !== d.truncated) begin
                        $error("truncated expected %0b actual %0b", d.truncated, m_tuser[1]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                idle_cnt = 0;
                it = comp_q.pop_front();
                predict_decode(it.data, it.last);
                beat_taken = 1'b1;
                in_cnt++;
                steady = (in_cnt >= 90 && in_cnt < 125);
            end
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int n;
        clear_window();

        // copy before chunk start, literals incl. marker value, long and short copies
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(8'hF8, 1'b0, 1'b0);
        push_byte(8'hF7, 1'b0, 1'b0);
        push_byte(8'h07, 1'b0, 1'b0);
        push_byte(8'hFE, 1'b1, 1'b0);
        // marker alone at chunk end
        push_byte(MARKER_BYTE, 1'b1, 1'b0);
        // literal as the final byte
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b1, 1'b0);
        // copy right after a clear reads zeros
        push_byte(8'h3B, 1'b1, 1'b0);
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(MARKER_BYTE, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h79, 1'b0, 1'b0);
        push_byte(MARKER_BYTE, 1'b1, 1'b0);

        // sender pauses here until the directed part has drained
        n = 0;
        push_byte(8'($urandom_range(0, 254)), 1'b1, 1'b1);
        n = 22;
        while (n < 170) begin
            push_random_chunk(n);
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (comp_q.size() != 0) begin
            @(posedge aclk);
        end
        while (decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/swlz_pkg.sv
design/short_window_lz_decoder.sv
design/swlz_checker.sv
tb/short_window_lz_decoder_test.sv
